// File: sv/assert_macros.svh
// Assertion macros used by the RTL top level of the circular queue.
// No dependencies; included by the top level, which checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every rising edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Checks that an antecedent implies a consequent in the following cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/cqr_pkg.sv
// Package of the circular queue: field widths, command and status codes, states.
// No dependencies; used by the top level of the block and its testbench.
`timescale 1ns / 1ps

package cqr_pkg;

    localparam int DEFAULT_MAX_DEPTH = 16;
    localparam int MAX_RESULTS       = 16;
    localparam int CAP_RESET         = 16;
    localparam int VAL_W             = 32;
    localparam int CNT_W             = 5;
    localparam int CODE_W            = 2;
    localparam int DATA_W            = 40;

    typedef enum logic [CODE_W-1:0] {
        CMD_ENQ  = 2'd0,
        CMD_DEQ  = 2'd1,
        CMD_ROT  = 2'd2,
        CMD_NONE = 2'd3
    } t_cmd;

    typedef enum logic [CODE_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_OVERFLOW  = 2'd1,
        STAT_UNDERFLOW = 2'd2,
        STAT_BADCOUNT  = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } t_state;

endpackage

// File: sv/cqr_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies; instantiated by the circular queue top level.
`timescale 1ns / 1ps

module cqr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/circular_queue_with_rotate.sv
// Top level of the circular queue of signed 32-bit words with rotate.
// Depends on cqr_pkg, cqr_ram and assert_macros.svh.
//
// Commands arrive on the s_axis channel, results leave on the m_axis channel.
// The capacity register is written through i_cfg_we and i_cfg_wdata; the user
// must do so only while the block is idle, which the block does not enforce.
// A write empties the queue; zero acts as one and above MAX_DEPTH as MAX_DEPTH.
// Enqueue and every error result load the output register as the command is
// accepted, so one such command passes per cycle while the receiver keeps up.
// Dequeue reads the word store, a RAM with a registered read port, and moves
// the word read into the output register once it is free, then goes idle.
// Rotate by k issues one read of the head slot per cycle while the receiver
// keeps up, writes each word back at the tail as it is emitted and yields k
// results; the next command is taken after the last one. Rotate by zero
// produces no result. A stalled receiver holds the output register and halts
// the rotate sequence until it takes the pending result.
// Reset clears head, tail, count and the output valid and sets the capacity
// to 16, limited to MAX_DEPTH; the word store is not cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module circular_queue_with_rotate #(
    parameter int MAX_DEPTH = cqr_pkg::DEFAULT_MAX_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [cqr_pkg::CNT_W-1:0]   i_cfg_wdata,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // data_value [31:0], rotate_count [36:32], zero fill [39:37]
    input  logic [cqr_pkg::DATA_W-1:0]  s_axis_tdata,
    // command [1:0]
    input  logic [cqr_pkg::CODE_W-1:0]  s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // out_value [31:0], occupancy [36:32], zero fill [39:37]
    output logic [cqr_pkg::DATA_W-1:0]  m_axis_tdata,
    // status [1:0]
    output logic [cqr_pkg::CODE_W-1:0]  m_axis_tuser,
    output logic                        m_axis_tlast
);

    localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int CW = (AW + 1 > cqr_pkg::CNT_W) ? AW + 1 : cqr_pkg::CNT_W;
    localparam int CAP_RST = (cqr_pkg::CAP_RESET > MAX_DEPTH) ? MAX_DEPTH
                                                              : cqr_pkg::CAP_RESET;

    function automatic logic [AW-1:0] f_wrap(input logic [AW-1:0] idx,
                                             input logic [cqr_pkg::CNT_W-1:0] cap);
        logic [CW-1:0] nx;
        nx = CW'(idx) + CW'(1);
        f_wrap = (nx >= CW'(cap)) ? '0 : nx[AW-1:0];
    endfunction

    cqr_pkg::t_state            r_state, n_state;
    logic [cqr_pkg::CNT_W-1:0]  r_cap, n_cap;
    logic [AW-1:0]              r_head, n_head;
    logic [AW-1:0]              r_tail, n_tail;
    logic [cqr_pkg::CNT_W-1:0]  r_count, n_count;
    logic [cqr_pkg::CNT_W-1:0]  r_left, n_left;
    logic                       r_is_rot, n_is_rot;
    logic                       r_byp, n_byp;
    logic [cqr_pkg::VAL_W-1:0]  r_byp_val, n_byp_val;

    logic                       r_ov, n_ov;
    logic [cqr_pkg::VAL_W-1:0]  r_oval, n_oval;
    cqr_pkg::t_status           r_ostat, n_ostat;
    logic                       r_olast, n_olast;
    logic [cqr_pkg::CNT_W-1:0]  r_oocc, n_oocc;

    logic                       w_out_free;
    logic                       w_accept;
    cqr_pkg::t_cmd              w_cmd;
    logic [cqr_pkg::VAL_W-1:0]  w_din;
    logic [cqr_pkg::CNT_W-1:0]  w_k;
    logic                       w_emit;
    logic                       w_we;
    logic [AW-1:0]              w_waddr;
    logic [cqr_pkg::VAL_W-1:0]  w_wdata;
    logic                       w_re;
    logic [cqr_pkg::VAL_W-1:0]  w_rdata;
    logic [cqr_pkg::VAL_W-1:0]  w_rd;
    logic [CW-1:0]              w_cfg_ext;

    assign w_out_free    = !r_ov || m_axis_tready;
    assign s_axis_tready = (r_state == cqr_pkg::S_IDLE) && w_out_free;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_cmd         = cqr_pkg::t_cmd'(s_axis_tuser);
    assign w_din         = s_axis_tdata[cqr_pkg::VAL_W-1:0];
    assign w_k           = s_axis_tdata[cqr_pkg::VAL_W +: cqr_pkg::CNT_W];
    assign w_emit        = (r_state == cqr_pkg::S_READ) && w_out_free;
    assign w_cfg_ext     = CW'(i_cfg_wdata);
    assign w_rd          = r_byp ? r_byp_val : w_rdata;

    // With a single word held, the rotate write at the tail and the read at the
    // head hit the same slot in one cycle; the written word is forwarded instead.
    cqr_ram #(
        .WIDTH (cqr_pkg::VAL_W),
        .DEPTH (MAX_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (r_head),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cqr_pkg::S_IDLE: begin
                if (w_accept && w_cmd == cqr_pkg::CMD_DEQ && r_count != '0) begin
                    n_state = cqr_pkg::S_READ;
                end else if (w_accept && w_cmd == cqr_pkg::CMD_ROT && w_k != '0
                             && w_k <= r_cap && 32'(w_k) <= cqr_pkg::MAX_RESULTS
                             && r_count != '0) begin
                    n_state = cqr_pkg::S_READ;
                end
            end
            cqr_pkg::S_READ: begin
                if (w_emit && (!r_is_rot || r_left == cqr_pkg::CNT_W'(1))) begin
                    n_state = cqr_pkg::S_IDLE;
                end
            end
            default: n_state = cqr_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_cap     = r_cap;
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_left    = r_left;
        n_is_rot  = r_is_rot;
        n_byp     = r_byp;
        n_byp_val = r_byp_val;
        n_ov      = r_ov && !m_axis_tready;
        n_oval    = r_oval;
        n_ostat   = r_ostat;
        n_olast   = r_olast;
        n_oocc    = r_oocc;
        w_we      = 1'b0;
        w_waddr   = r_tail;
        w_wdata   = w_din;
        w_re      = 1'b0;

        priority if (i_cfg_we) begin
            if (i_cfg_wdata == '0) begin
                n_cap = cqr_pkg::CNT_W'(1);
            end else if (w_cfg_ext > CW'(MAX_DEPTH)) begin
                n_cap = cqr_pkg::CNT_W'(MAX_DEPTH);
            end else begin
                n_cap = i_cfg_wdata;
            end
            n_head  = '0;
            n_tail  = '0;
            n_count = '0;
        end else if (w_accept) begin
            n_olast = 1'b1;
            n_oocc  = r_count;
            n_oval  = '0;
            n_byp   = 1'b0;
            unique case (w_cmd)
                cqr_pkg::CMD_ENQ: begin
                    n_ov = 1'b1;
                    if (r_count >= r_cap) begin
                        n_ostat = cqr_pkg::STAT_OVERFLOW;
                    end else begin
                        w_we    = 1'b1;
                        n_tail  = f_wrap(r_tail, r_cap);
                        n_count = r_count + cqr_pkg::CNT_W'(1);
                        n_oocc  = r_count + cqr_pkg::CNT_W'(1);
                        n_ostat = cqr_pkg::STAT_OK;
                    end
                end
                cqr_pkg::CMD_DEQ: begin
                    if (r_count == '0) begin
                        n_ov    = 1'b1;
                        n_oval  = '1;
                        n_ostat = cqr_pkg::STAT_UNDERFLOW;
                    end else begin
                        w_re     = 1'b1;
                        n_head   = f_wrap(r_head, r_cap);
                        n_count  = r_count - cqr_pkg::CNT_W'(1);
                        n_is_rot = 1'b0;
                    end
                end
                cqr_pkg::CMD_ROT: begin
                    if (w_k > r_cap || 32'(w_k) > cqr_pkg::MAX_RESULTS) begin
                        n_ov    = 1'b1;
                        n_ostat = cqr_pkg::STAT_BADCOUNT;
                    end else if (w_k == '0) begin
                        n_ov = r_ov && !m_axis_tready;
                    end else if (r_count == '0) begin
                        n_ov    = 1'b1;
                        n_oval  = '1;
                        n_ostat = cqr_pkg::STAT_UNDERFLOW;
                    end else begin
                        w_re     = 1'b1;
                        n_head   = f_wrap(r_head, r_cap);
                        n_left   = w_k;
                        n_is_rot = 1'b1;
                    end
                end
                cqr_pkg::CMD_NONE: begin
                    n_ov = r_ov && !m_axis_tready;
                end
                default: n_ov = r_ov && !m_axis_tready;
            endcase
        end else if (w_emit) begin
            n_ov    = 1'b1;
            n_oval  = w_rd;
            n_ostat = cqr_pkg::STAT_OK;
            n_oocc  = r_count;
            if (r_is_rot) begin
                n_olast = (r_left == cqr_pkg::CNT_W'(1));
                w_we    = 1'b1;
                w_wdata = w_rd;
                n_tail  = f_wrap(r_tail, r_cap);
                n_left  = r_left - cqr_pkg::CNT_W'(1);
                if (r_left != cqr_pkg::CNT_W'(1)) begin
                    w_re      = 1'b1;
                    n_head    = f_wrap(r_head, r_cap);
                    n_byp     = (r_head == r_tail);
                    n_byp_val = w_rd;
                end
            end else begin
                n_olast = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= cqr_pkg::S_IDLE;
            r_cap    <= cqr_pkg::CNT_W'(CAP_RST);
            r_head   <= '0;
            r_tail   <= '0;
            r_count  <= '0;
            r_left   <= '0;
            r_is_rot <= 1'b0;
            r_byp    <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cap    <= n_cap;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_count  <= n_count;
            r_left   <= n_left;
            r_is_rot <= n_is_rot;
            r_byp    <= n_byp;
            r_ov     <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byp_val <= n_byp_val;
        r_oval    <= n_oval;
        r_ostat   <= n_ostat;
        r_olast   <= n_olast;
        r_oocc    <= n_oocc;
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {{(cqr_pkg::DATA_W - cqr_pkg::VAL_W - cqr_pkg::CNT_W){1'b0}},
                            r_oocc, r_oval};
    assign m_axis_tuser  = r_ostat;
    assign m_axis_tlast  = r_olast;

    `ASSERT_ALWAYS(a_count_in_cap, i_clk, i_rst_n, r_count <= r_cap,
        "entry count exceeds capacity")
    `ASSERT_ALWAYS(a_no_accept_in_read, i_clk, i_rst_n,
        !(r_state == cqr_pkg::S_READ && s_axis_tready),
        "input accepted while a read is pending")
    `ASSERT_NEXT(a_rotate_keeps_count, i_clk, i_rst_n,
        r_state == cqr_pkg::S_READ && r_is_rot, r_count == $past(r_count),
        "rotate changed the entry count")
    `ASSERT_ALWAYS(a_rotate_left_nonzero, i_clk, i_rst_n,
        !(r_state == cqr_pkg::S_READ && r_is_rot && r_left == '0),
        "rotate sequence running with no moves left")

endmodule

// File: tb/tb_circular_queue_with_rotate.sv
`timescale 1ns / 1ps
// Self-checking testbench of circular_queue_with_rotate: directed and random command
// streams under varying handshake pressure, checked against a built-in queue predictor.
// Depends on cqr_pkg and the RTL of the block only.

module tb_circular_queue_with_rotate;

    localparam int IDX_W        = $clog2(cqr_pkg::DEFAULT_MAX_DEPTH);
    localparam int FILL_W       = cqr_pkg::DATA_W - cqr_pkg::VAL_W - cqr_pkg::CNT_W;
    localparam int VAL_W        = cqr_pkg::VAL_W;
    localparam int CNT_W        = cqr_pkg::CNT_W;
    localparam int CODE_W       = cqr_pkg::CODE_W;
    localparam int DATA_W       = cqr_pkg::DATA_W;
    localparam int STALL_LIMIT  = 2000;
    localparam int PAUSE_CYCLES = 24;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS  = 60;

    typedef struct {
        logic [VAL_W-1:0] value;
        cqr_pkg::t_status status;
        logic             last;
        logic [CNT_W-1:0] occupancy;
    } t_queue_result;

    class t_queue_tracker;
        logic [VAL_W-1:0] slot_words [cqr_pkg::DEFAULT_MAX_DEPTH];
        logic [IDX_W-1:0] head_slot;
        logic [IDX_W-1:0] tail_slot;
        logic [CNT_W-1:0] held_count;
        logic [CNT_W-1:0] capacity;
        t_queue_result    predicted_results [$];
        int               mismatches;
        int               commands_seen;
        int               results_seen;
        int               capacity_writes;

        function new();
            head_slot       = '0;
            tail_slot       = '0;
            held_count      = '0;
            capacity        = CNT_W'((cqr_pkg::CAP_RESET > cqr_pkg::DEFAULT_MAX_DEPTH)
                                     ? cqr_pkg::DEFAULT_MAX_DEPTH : cqr_pkg::CAP_RESET);
            mismatches      = 0;
            commands_seen   = 0;
            results_seen    = 0;
            capacity_writes = 0;
        endfunction

        function logic [IDX_W-1:0] next_slot(logic [IDX_W-1:0] idx);
            logic [CNT_W-1:0] bumped;
            bumped = CNT_W'(idx) + CNT_W'(1);
            return (bumped >= capacity) ? '0 : bumped[IDX_W-1:0];
        endfunction

        function void push_result(logic [VAL_W-1:0] value, cqr_pkg::t_status status,
                                  logic last);
            t_queue_result r;
            r.value     = value;
            r.status    = status;
            r.last      = last;
            r.occupancy = held_count;
            predicted_results.push_back(r);
        endfunction

        function void write_capacity(logic [CNT_W-1:0] req);
            if (req == 0) begin
                capacity = CNT_W'(1);
            end else if (req > cqr_pkg::DEFAULT_MAX_DEPTH) begin
                capacity = CNT_W'(cqr_pkg::DEFAULT_MAX_DEPTH);
            end else begin
                capacity = req;
            end
            head_slot  = '0;
            tail_slot  = '0;
            held_count = '0;
            capacity_writes++;
        endfunction

        function void apply_command(cqr_pkg::t_cmd cmd, logic [VAL_W-1:0] word,
                                    logic [CNT_W-1:0] moves);
            logic [VAL_W-1:0] moved;
            commands_seen++;
            if (head_slot >= capacity) head_slot = '0;
            if (tail_slot >= capacity) tail_slot = '0;
            case (cmd)
                cqr_pkg::CMD_ENQ: begin
                    if (held_count >= capacity) begin
                        push_result('0, cqr_pkg::STAT_OVERFLOW, 1'b1);
                    end else begin
                        slot_words[tail_slot] = word;
                        tail_slot = next_slot(tail_slot);
                        held_count++;
                        push_result('0, cqr_pkg::STAT_OK, 1'b1);
                    end
                end
                cqr_pkg::CMD_DEQ: begin
                    if (held_count == 0) begin
                        push_result('1, cqr_pkg::STAT_UNDERFLOW, 1'b1);
                    end else begin
                        moved = slot_words[head_slot];
                        head_slot = next_slot(head_slot);
                        held_count--;
                        push_result(moved, cqr_pkg::STAT_OK, 1'b1);
                    end
                end
                cqr_pkg::CMD_ROT: begin
                    if (moves > capacity || moves > cqr_pkg::MAX_RESULTS) begin
                        push_result('0, cqr_pkg::STAT_BADCOUNT, 1'b1);
                    end else if (moves != 0) begin
                        if (held_count == 0) begin
                            push_result('1, cqr_pkg::STAT_UNDERFLOW, 1'b1);
                        end else begin
                            for (int i = 0; i < moves; i++) begin
                                moved = slot_words[head_slot];
                                head_slot = next_slot(head_slot);
                                slot_words[tail_slot] = moved;
                                tail_slot = next_slot(tail_slot);
                                push_result(moved, cqr_pkg::STAT_OK, (i + 1 == moves));
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        endfunction

        task report_mismatch(string what, logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
            $display("[%0t] mismatch in %s: got %h, expected %h", $time, what, got, want);
            mismatches++;
        endtask

        task check_output(logic [VAL_W-1:0] value, logic [CODE_W-1:0] status,
                          logic last, logic [CNT_W-1:0] occupancy);
            t_queue_result want;
            results_seen++;
            if (predicted_results.size() == 0) begin
                report_mismatch("result with none pending (value)", value, '0);
                return;
            end
            want = predicted_results.pop_front();
            if (value !== want.value) report_mismatch("out_value", value, want.value);
            if (status !== want.status) begin
                report_mismatch("status", VAL_W'(status), VAL_W'(want.status));
            end
            if (last !== want.last) begin
                report_mismatch("last_of_run", VAL_W'(last), VAL_W'(want.last));
            end
            if (occupancy !== want.occupancy) begin
                report_mismatch("occupancy", VAL_W'(occupancy), VAL_W'(want.occupancy));
            end
        endtask
    endclass

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_we      = 1'b0;
    logic [CNT_W-1:0]   i_cfg_wdata   = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [DATA_W-1:0]  s_axis_tdata  = '0;
    logic [CODE_W-1:0]  s_axis_tuser  = cqr_pkg::CMD_NONE;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [DATA_W-1:0]  m_axis_tdata;
    logic [CODE_W-1:0]  m_axis_tuser;
    logic               m_axis_tlast;

    t_queue_tracker tracker;
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int quiet_cycles   = 0;
    int cap_plan [8]   = '{31, 1, 6, 16, 2, 11, 0, 16};

    circular_queue_with_rotate uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Results are checked before the input transaction of the same edge is noted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) tracker.write_capacity(i_cfg_wdata);
            if (m_axis_tvalid && m_axis_tready) begin
                tracker.check_output(m_axis_tdata[VAL_W-1:0], m_axis_tuser, m_axis_tlast,
                                     m_axis_tdata[VAL_W+CNT_W-1:VAL_W]);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                tracker.apply_command(cqr_pkg::t_cmd'(s_axis_tuser),
                                      s_axis_tdata[VAL_W-1:0],
                                      s_axis_tdata[VAL_W+CNT_W-1:VAL_W]);
            end
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)
                    || i_cfg_we) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Run stalled after %0d commands and %0d results.",
                         tracker.commands_seen, tracker.results_seen);
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic send_command(cqr_pkg::t_cmd cmd, logic [VAL_W-1:0] word,
                                logic [CNT_W-1:0] moves);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{FILL_W{1'b0}}, moves, word};
        s_axis_tuser  <= cmd;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic wait_until_drained(int extra_cycles);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (tracker.predicted_results.size() != 0) @(posedge i_clk);
        repeat (extra_cycles) @(posedge i_clk);
    endtask

    task automatic set_capacity(logic [CNT_W-1:0] req);
        wait_until_drained(PAUSE_CYCLES);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= req;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic run_random_phase(int idle_pct, int stall_pct);
        int fill_bias;
        int pick;
        logic [VAL_W-1:0] word;
        logic [CNT_W-1:0] moves;
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        fill_bias      = 50;
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 20 == 0) fill_bias = ($urandom_range(1) != 0) ? 70 : 30;
            if ($urandom_range(9) == 0) begin
                case ($urandom_range(3))
                    0: word = 32'h8000_0000;
                    1: word = 32'h7FFF_FFFF;
                    2: word = 32'hFFFF_FFFF;
                    default: word = 32'h0000_0000;
                endcase
            end else begin
                word = $urandom();
            end
            pick = $urandom_range(9);
            if (pick == 0) begin
                moves = '0;
            end else if (pick == 1) begin
                moves = CNT_W'($urandom_range(cqr_pkg::MAX_RESULTS));
            end else begin
                moves = CNT_W'($urandom_range(tracker.capacity, 1));
            end
            pick = $urandom_range(99);
            if (pick < 3) begin
                send_command(cqr_pkg::CMD_NONE, word, moves);
            end else if (pick < 23) begin
                send_command(cqr_pkg::CMD_ROT, word, moves);
            end else if ($urandom_range(99) < fill_bias) begin
                send_command(cqr_pkg::CMD_ENQ, word, moves);
            end else begin
                send_command(cqr_pkg::CMD_DEQ, word, moves);
            end
        end
    endtask

    initial begin
        tracker = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_command(cqr_pkg::CMD_DEQ, 32'h1234_5678, 5'd0);
        send_command(cqr_pkg::CMD_ROT, 32'h0, 5'd3);
        send_command(cqr_pkg::CMD_ROT, 32'h0, 5'd0);
        send_command(cqr_pkg::CMD_NONE, 32'hDEAD_BEEF, 5'd31);
        send_command(cqr_pkg::CMD_ENQ, 32'h8000_0000, 5'd0);
        send_command(cqr_pkg::CMD_ENQ, 32'h7FFF_FFFF, 5'd16);
        send_command(cqr_pkg::CMD_ENQ, 32'hFFFF_FFFF, 5'd0);
        send_command(cqr_pkg::CMD_ENQ, 32'hAAAA_AAAA, 5'd0);
        send_command(cqr_pkg::CMD_ROT, 32'h0, 5'd2);
        send_command(cqr_pkg::CMD_ROT, 32'h0, 5'd0);
        send_command(cqr_pkg::CMD_ROT, 32'h0, 5'd16);
        send_command(cqr_pkg::CMD_DEQ, 32'h0, 5'd0);

        set_capacity(5'd0);
        send_command(cqr_pkg::CMD_ENQ, 32'h5555_5555, 5'd0);
        send_command(cqr_pkg::CMD_ENQ, 32'h0000_0000, 5'd0);
        send_command(cqr_pkg::CMD_ROT, 32'h0, 5'd1);
        send_command(cqr_pkg::CMD_ROT, 32'h0, 5'd2);
        send_command(cqr_pkg::CMD_DEQ, 32'h0, 5'd0);
        send_command(cqr_pkg::CMD_DEQ, 32'h0, 5'd0);

        set_capacity(5'd2);
        send_command(cqr_pkg::CMD_ENQ, 32'h0000_0001, 5'd0);
        send_command(cqr_pkg::CMD_ENQ, 32'h0000_0002, 5'd0);
        send_command(cqr_pkg::CMD_ENQ, 32'h0000_0003, 5'd0);
        send_command(cqr_pkg::CMD_ROT, 32'h0, 5'd2);

        foreach (cap_plan[p]) begin
            set_capacity(CNT_W'(cap_plan[p]));
            case (p % 4)
                0: run_random_phase(0, 0);
                1: run_random_phase(46, 0);
                2: run_random_phase(0, 46);
                default: run_random_phase(38, 38);
            endcase
        end

        wait_until_drained(DRAIN_CYCLES);
        $display("Run covered %0d commands and %0d results over %0d capacity writes,",
                 tracker.commands_seen, tracker.results_seen, tracker.capacity_writes);
        $display("with idle sender, stalling receiver, both, and neither.");
        if (tracker.mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+sv
sv/cqr_pkg.sv
sv/cqr_ram.sv
sv/circular_queue_with_rotate.sv
tb/tb_circular_queue_with_rotate.sv
